>>> src/running_kth_largest_select_macros.svh
// Assertion helpers shared by the running k-th largest select block
`ifndef RUNNING_KTH_LARGEST_SELECT_MACROS_SVH
`define RUNNING_KTH_LARGEST_SELECT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define KRS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define KRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/krs_pkg.sv
package krs_pkg;

   // Store depth and readout grouping
   localparam int CAPACITY_DEFAULT = 256;
   localparam int GROUP_SIZE       = 64;

   // Field widths
   localparam int VALUE_W = 32;
   localparam int RATIO_W = 16;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [RATIO_W-1:0]        ratio_type;

   localparam ratio_type RATIO_RESET = ratio_type'(1);

   // Broadcast from the top level to every cell of the chain
   typedef struct packed {
      logic      shift_en;
      value_type ins_value;
   } cell_ctrl_type;

endpackage

>>> src/krs_req_if.sv
interface krs_req_if import krs_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

>>> src/krs_rsp_if.sv
interface krs_rsp_if import krs_pkg::*; ();
   logic      valid;
   logic      ready;
   value_type kth_value;
   logic      dropped;

   modport source (output valid, output kth_value, output dropped, input ready);
   modport sink   (input valid, input kth_value, input dropped, output ready);
endinterface

>>> src/krs_cell.sv
module krs_cell import krs_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT,
   parameter int INDEX    = 0,
   localparam int CNT_W   = $clog2(CAPACITY + 1),
   localparam int IDX_W   = $clog2(CAPACITY)
) (
   input  logic             clock,
   input  cell_ctrl_type    ctrl,
   input  logic [CNT_W-1:0] count,
   input  logic [IDX_W-1:0] rank_idx,
   input  value_type        prev_value,
   input  logic             prev_ge,
   output value_type        value,
   output logic             ge,
   output value_type        sel_value
);

   value_type value_ff;
   value_type value_in;
   logic      occupied;

   // Entry is live when it sits below the fill level
   assign occupied = CNT_W'(INDEX) < count;
   assign ge       = occupied && (value_ff >= ctrl.ins_value);

   // Keep when not smaller; take the new sample at the insert point; else shift down
   always_comb begin
      if (ge) begin
         value_in = value_ff;
      end else if (prev_ge) begin
         value_in = ctrl.ins_value;
      end else begin
         value_in = prev_value;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift_en) begin
         value_ff <= value_in;
      end
   end

   assign value     = value_ff;
   assign sel_value = (rank_idx == IDX_W'(INDEX)) ? value_ff : '0;

endmodule

>>> src/krs_rank.sv
module krs_rank import krs_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT,
   localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  ratio_type        csr_wr_data,
   input  logic [CNT_W-1:0] count,
   input  logic             inc,
   output logic             busy,
   output logic [CNT_W-1:0] k
);

   localparam int STEP_W = $clog2(CNT_W + 1);

   typedef enum logic [1:0] {
      RK_IDLE   = 2'b01,
      RK_DIVIDE = 2'b10
   } rank_state_type;

   rank_state_type    state_ff, state_in;
   ratio_type         div_ff, div_in;
   ratio_type         rem_ff, rem_in;
   ratio_type         prem_ff, prem_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [CNT_W-1:0]  qd_ff, qd_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic [RATIO_W:0]  trial;
   logic [RATIO_W:0]  diff;
   logic              fits;
   ratio_type         prem_next;
   logic [CNT_W-1:0]  qd_next;

   // One restoring division step: bring down the next count bit
   assign trial     = {prem_ff, qd_ff[CNT_W-1]};
   assign diff      = trial - {1'b0, div_ff};
   assign fits      = trial >= {1'b0, div_ff};
   assign prem_next = fits ? diff[RATIO_W-1:0] : trial[RATIO_W-1:0];
   assign qd_next   = {qd_ff[CNT_W-2:0], fits};

   always_comb begin
      state_in = state_ff;
      div_in   = div_ff;
      rem_in   = rem_ff;
      prem_in  = prem_ff;
      k_in     = k_ff;
      qd_in    = qd_ff;
      step_in  = step_ff;

      unique case (state_ff)
         RK_IDLE: begin
            // Advance the rank by one every ratio insertions
            if (inc) begin
               if (rem_ff == div_ff) begin
                  k_in   = k_ff + CNT_W'(1);
                  rem_in = ratio_type'(1);
               end else begin
                  rem_in = rem_ff + ratio_type'(1);
               end
            end
         end
         RK_DIVIDE: begin
            prem_in = prem_next;
            qd_in   = qd_next;
            step_in = step_ff - STEP_W'(1);
            // Last step: rank is the rounded-up quotient
            if (step_ff == STEP_W'(1)) begin
               state_in = RK_IDLE;
               k_in     = qd_next + CNT_W'(prem_next != '0);
               rem_in   = (prem_next == '0) ? div_ff : prem_next;
            end
         end
         default: begin
            state_in = RK_IDLE;
         end
      endcase

      // New ratio: recompute the rank of the current fill level
      if (csr_wr_en) begin
         state_in = RK_DIVIDE;
         div_in   = (csr_wr_data == '0) ? ratio_type'(1) : csr_wr_data;
         prem_in  = '0;
         qd_in    = count;
         step_in  = STEP_W'(CNT_W);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= RK_IDLE;
         div_ff   <= RATIO_RESET;
         rem_ff   <= RATIO_RESET;
         k_ff     <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         div_ff   <= div_in;
         rem_ff   <= rem_in;
         k_ff     <= k_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      prem_ff <= prem_in;
      qd_ff   <= qd_in;
   end

   assign busy = (state_ff == RK_DIVIDE);
   assign k    = k_ff;

endmodule

>>> src/krs_gather.sv
module krs_gather import krs_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic      clock,
   input  logic      load,
   input  value_type sel_values [CAPACITY],
   output value_type kth_value
);

   localparam int GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

   value_type group_ff [GROUPS];
   value_type group_in [GROUPS];

   // Merge the masked cell outputs of each group; only one cell is selected
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         group_in[g] = '0;
         for (int c = 0; c < GROUP_SIZE; c++) begin
            if (g * GROUP_SIZE + c < CAPACITY) begin
               group_in[g] = group_in[g] | sel_values[g * GROUP_SIZE + c];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         group_ff <= group_in;
      end
   end

   // Merge the group results
   always_comb begin
      kth_value = '0;
      for (int g = 0; g < GROUPS; g++) begin
         kth_value = kth_value | group_ff[g];
      end
   end

endmodule

>>> src/running_kth_largest_select.sv
// Running k-th largest select.
// Each transaction on req_if carries one signed sample, which is inserted into
// a sorted chain of CAPACITY cells (duplicates kept). One transaction on rsp_if
// follows for each one accepted: the k-th largest stored sample, with
// k = ceil(stored count / ratio), and a dropped flag that is set when the chain
// was already full and the sample was discarded.
// The ratio register is written through csr_wr_en / csr_wr_data; a value of
// zero acts as one. A write starts a bit-serial division of the fill level;
// req_if.ready is low meanwhile.
// The sample is inserted into the chain at the accepting edge, the rank cell
// is then selected per group into the group registers, and the group results
// are merged into the output register. A new transaction is accepted only
// after the previous one has left the insert stage, once its rank cell has
// been sampled into the group registers.
// Reset empties the store and sets ratio to 1. When rsp_if stalls, up to three
// transactions are held inside (insert stage, readout stage, output register)
// and req_if.ready stays low until the insert stage drains.
`include "running_kth_largest_select_macros.svh"

module running_kth_largest_select import krs_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  ratio_type   csr_wr_data,
   krs_req_if.sink     req_if,
   krs_rsp_if.source   rsp_if
);

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = $clog2(CAPACITY);

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] k_w;
   logic [CNT_W-1:0] k_minus;
   logic [IDX_W-1:0] rank_idx;
   logic             rank_busy;
   logic             full;
   logic             accept;
   logic             ins;

   logic             p1_vld_ff, p1_vld_in;
   logic             p1_drop_ff;
   logic             p2_vld_ff, p2_vld_in;
   logic             p2_drop_ff;
   logic             rsp_vld_ff, rsp_vld_in;
   logic             rsp_drop_ff;
   value_type        rsp_value_ff;
   logic             p1_move;
   logic             p2_move;
   value_type        merged_value;

   cell_ctrl_type    cell_ctrl;
   value_type        cell_value [CAPACITY];
   logic             cell_ge    [CAPACITY];
   value_type        cell_sel   [CAPACITY];
   value_type        prev_value [CAPACITY];
   logic             prev_ge    [CAPACITY];

   // Input handshake: one transaction in the insert stage at a time, none while the rank divides
   assign req_if.ready = !p1_vld_ff && !rank_busy;
   assign accept       = req_if.valid && req_if.ready;
   assign full         = (count_ff == CNT_W'(CAPACITY));
   assign ins          = accept && !full;

   assign cell_ctrl.shift_en  = ins;
   assign cell_ctrl.ins_value = req_if.value;

   // Fill level
   assign count_in = ins ? count_ff + CNT_W'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Sorted cell chain, largest at cell 0
   for (genvar i = 0; i < CAPACITY; i++) begin : g_chain
      if (i == 0) begin : g_head
         assign prev_value[i] = req_if.value;
         assign prev_ge[i]    = 1'b1;
      end else begin : g_body
         assign prev_value[i] = cell_value[i-1];
         assign prev_ge[i]    = cell_ge[i-1];
      end

      krs_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (cell_ctrl),
         .count      (count_ff),
         .rank_idx   (rank_idx),
         .prev_value (prev_value[i]),
         .prev_ge    (prev_ge[i]),
         .value      (cell_value[i]),
         .ge         (cell_ge[i]),
         .sel_value  (cell_sel[i])
      );
   end

   // Rank tracking
   krs_rank #(
      .CAPACITY (CAPACITY)
   ) u_rank (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .count       (count_ff),
      .inc         (ins),
      .busy        (rank_busy),
      .k           (k_w)
   );

   assign k_minus  = k_w - CNT_W'(1);
   assign rank_idx = k_minus[IDX_W-1:0];

   // Readout of the rank cell
   krs_gather #(
      .CAPACITY (CAPACITY)
   ) u_gather (
      .clock      (clock),
      .load       (p1_move),
      .sel_values (cell_sel),
      .kth_value  (merged_value)
   );

   // Advance the pipeline when the next stage is free or draining
   assign p2_move = p2_vld_ff && (!rsp_vld_ff || rsp_if.ready);
   assign p1_move = p1_vld_ff && (!p2_vld_ff || p2_move);

   assign p1_vld_in  = accept || (p1_vld_ff && !p1_move);
   assign p2_vld_in  = p1_move || (p2_vld_ff && !p2_move);
   assign rsp_vld_in = p2_move || (rsp_vld_ff && !rsp_if.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff  <= 1'b0;
         p2_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff  <= p1_vld_in;
         p2_vld_ff  <= p2_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // Hold the drop flag alongside each transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         p1_drop_ff <= full;
      end
      if (p1_move) begin
         p2_drop_ff <= p1_drop_ff;
      end
      if (p2_move) begin
         rsp_drop_ff  <= p2_drop_ff;
         rsp_value_ff <= merged_value;
      end
   end

   assign rsp_if.valid     = rsp_vld_ff;
   assign rsp_if.kth_value = rsp_value_ff;
   assign rsp_if.dropped   = rsp_drop_ff;

   // Checks
   `KRS_ASSERT_IMPLY(a_rank_in_range, clock, reset, !rank_busy, (k_w <= count_ff) && ((count_ff == '0) || (k_w != '0)), "rank outside the stored range")
   `KRS_ASSERT_NEXT(a_insert_counts, clock, reset, ins, count_ff == $past(count_ff) + CNT_W'(1), "insert did not grow the store")
   `KRS_ASSERT_NEXT(a_drop_when_full, clock, reset, accept, p1_drop_ff == $past(full), "drop flag does not match store fill")

endmodule

>>> bench/running_kth_largest_select_test.sv
`timescale 1ns / 1ps

module running_kth_largest_select_test;
   import krs_pkg::*;

   localparam int STORE_DEPTH = CAPACITY_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_LIMIT = 200;
   localparam int SETTLE_CYCLES = 6;
   localparam int PHASE_ITEMS = 50;

   typedef struct packed {
      value_type kth_value;
      logic      dropped;
   } answer_type;

   logic      clock;
   logic      reset;
   logic      csr_wr_en;
   ratio_type csr_wr_data;

   krs_req_if req_bus ();
   krs_rsp_if rsp_bus ();

   // Samples waiting to be driven, and answers waiting to be seen
   value_type  pending_samples[$];
   answer_type expected_answers[$];

   // Local copy of the sorted store, its fill level and the ratio
   value_type ranked_samples[STORE_DEPTH];
   int        held_count;
   ratio_type model_ratio;

   logic calm_stretch;
   int   mismatch_count;
   int   cycle_count;

   running_kth_largest_select u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Insert one sample (unless the store is full) and pick the k-th largest
   function automatic answer_type insert_and_rank(value_type sample);
      answer_type result;
      int slot;
      int divisor;
      int rank;
      result.dropped = 1'b0;
      result.kth_value = '0;
      if (held_count >= STORE_DEPTH) begin
         result.dropped = 1'b1;
      end else begin
         slot = held_count;
         // shift smaller entries one place toward the tail
         while (slot > 0 && ranked_samples[slot-1] < sample) begin
            ranked_samples[slot] = ranked_samples[slot-1];
            slot--;
         end
         ranked_samples[slot] = sample;
         held_count++;
      end
      divisor = (model_ratio == '0) ? 1 : int'(model_ratio);
      rank = (held_count + divisor - 1) / divisor;
      if (rank == 0) begin
         rank = 1;
      end
      if (held_count > 0 && rank <= held_count) begin
         result.kth_value = ranked_samples[rank-1];
      end
      return result;
   endfunction

   // Mix of full-range values, small values that repeat, and values near the limits
   function automatic value_type random_sample();
      value_type sample;
      case ($urandom_range(0, 5))
         3: sample = value_type'($urandom_range(0, 16) - 8);
         4: sample = value_type'(32'h7fff_ffff - $urandom_range(0, 3));
         5: sample = value_type'(32'h8000_0000 + $urandom_range(0, 3));
         default: sample = value_type'($urandom);
      endcase
      return sample;
   endfunction

   // Driver: advance to the next sample after each accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_answers.push_back(insert_and_rank(req_bus.value));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_samples.size() != 0 &&
                (calm_stretch || $urandom_range(0, 99) >= 6)) begin
               req_bus.valid <= 1'b1;
               req_bus.value <= pending_samples.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result transaction against the oldest answer
   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_answers.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: unexpected result expected none actual %0d/%0b",
                           $time, rsp_bus.kth_value, rsp_bus.dropped);
            end else begin
               want = expected_answers.pop_front();
               if (rsp_bus.kth_value !== want.kth_value) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("%0t: kth_value expected %0d actual %0d",
                              $time, want.kth_value, rsp_bus.kth_value);
               end
               if (rsp_bus.dropped !== want.dropped) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("%0t: dropped expected %0b actual %0b",
                              $time, want.dropped, rsp_bus.dropped);
               end
            end
         end
         rsp_bus.ready <= calm_stretch || ($urandom_range(0, 99) >= 6);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Hold until every sample is accepted and every answer has arrived
   task automatic wait_for_drain();
      @(negedge clock);
      while (pending_samples.size() != 0 || req_bus.valid ||
             expected_answers.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_ratio(ratio_type setting);
      wait_for_drain();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= setting;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      model_ratio = setting;
   endtask

   task automatic queue_random(int count);
      @(negedge clock);
      repeat (count) pending_samples.push_back(random_sample());
   endtask

   initial begin
      ratio_type phase_ratio[10];
      reset          = 1'b1;
      csr_wr_en      = 1'b0;
      csr_wr_data    = RATIO_RESET;
      req_bus.valid  = 1'b0;
      req_bus.value  = '0;
      rsp_bus.ready  = 1'b0;
      held_count     = 0;
      model_ratio    = RATIO_RESET;
      calm_stretch   = 1'b0;
      mismatch_count = 0;
      cycle_count    = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: first sample answers itself, then limits and duplicates at ratio 1
      @(negedge clock);
      pending_samples.push_back(value_type'(5));
      pending_samples.push_back(value_type'(32'h8000_0000));
      pending_samples.push_back(value_type'(32'h7fff_ffff));
      pending_samples.push_back(value_type'(0));
      pending_samples.push_back(value_type'(-1));
      pending_samples.push_back(value_type'(1));
      pending_samples.push_back(value_type'(5));
      pending_samples.push_back(value_type'(5));
      pending_samples.push_back(value_type'(32'h8000_0000));
      pending_samples.push_back(value_type'(32'h7fff_ffff));

      // Ratio above the count selects the largest
      write_ratio(ratio_type'(16'hffff));
      @(negedge clock);
      pending_samples.push_back(value_type'(-7));
      pending_samples.push_back(value_type'(100));
      pending_samples.push_back(value_type'(0));

      // Ratio zero acts as one and selects the smallest
      write_ratio(ratio_type'(0));
      @(negedge clock);
      pending_samples.push_back(value_type'(3));
      pending_samples.push_back(value_type'(-3));
      pending_samples.push_back(value_type'(32'h8000_0000));

      write_ratio(ratio_type'(2));
      @(negedge clock);
      pending_samples.push_back(value_type'(2));
      pending_samples.push_back(value_type'(2));
      pending_samples.push_back(value_type'(-2));

      // Random phases; the store fills up and later samples are dropped
      phase_ratio[0] = ratio_type'(3);
      phase_ratio[1] = ratio_type'(1);
      phase_ratio[2] = ratio_type'($urandom_range(1, 40));
      phase_ratio[3] = ratio_type'(16'hffff);
      phase_ratio[4] = ratio_type'(2);
      phase_ratio[5] = ratio_type'(0);
      phase_ratio[6] = ratio_type'(255);
      phase_ratio[7] = ratio_type'(256);
      phase_ratio[8] = ratio_type'($urandom_range(1, 65535));
      phase_ratio[9] = ratio_type'(1);
      foreach (phase_ratio[p]) begin
         write_ratio(phase_ratio[p]);
         calm_stretch = (p == 2);
         queue_random(PHASE_ITEMS);
      end

      wait_for_drain();
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
